// ===== hdl/sdu_pkg.sv =====
package sdu_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;

    // one slot of the chain: a stored element or an element in flight
    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] val;
    } t_elem;

    // controls shared by every cell
    typedef struct packed {
        logic probe;   // store full: match only, never insert or swap
        logic shift;   // drain: take the neighbor's element
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DRAIN
    } t_state;

endpackage

// ===== hdl/sorted_distinct_union.sv =====
// Sorted distinct union. Signed 32-bit values arrive on the slave stream; tlast
// marks the final value of a data set. Each value runs down a chain of
// CAPACITY cells that keep the distinct values seen so far in ascending order:
// a value settles in the first free cell, is merged where it meets an equal
// value, and otherwise swaps into place and pushes larger values one cell to
// the right. When the chain is full, a new value only searches for a match and
// is dropped if none is found, which raises the overflow flag. One value is
// handled at a time, one cell per cycle: the next request is taken only after
// the previous one has merged, settled, or walked the full chain and been
// dropped and the block is idle again. After the marked value the chain
// shifts toward cell 0 and sends every distinct value, smallest first, one per
// cycle under master backpressure; the greatest carries tlast and every result
// carries the overflow flag in tuser. Input is not taken while results are
// being sent; the block is ready again in the cycle after the last result is
// taken.
module sorted_distinct_union (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,   // last

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value_res
    output logic        m_axis_tlast,   // last_res
    output logic [0:0]  m_axis_tuser    // [0] overflowed
);

    localparam int CAP = sdu_pkg::CAPACITY;

    sdu_pkg::t_state r_state;
    sdu_pkg::t_state n_state;

    logic                       r_car0_vld;
    logic [sdu_pkg::DATA_W-1:0] r_car0_val;
    logic                       r_probe;
    logic                       r_last;
    logic                       r_ovf;

    sdu_pkg::t_elem     car [0:CAP];  // car[i] enters cell i; car[CAP] left the chain
    sdu_pkg::t_elem     st  [0:CAP];  // st[CAP] is the empty slot past the end
    logic [CAP:0]       car_vld;
    logic               car_any;
    sdu_pkg::t_cell_ctl ctl;

    logic s_acc;
    logic m_acc;
    logic drain_end;

    assign car[0] = '{vld: r_car0_vld, val: r_car0_val};
    assign st[CAP] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++) begin : g_cell
            sdu_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_car   (car[gi]),
                .i_nbr   (st[gi+1]),
                .o_car   (car[gi+1]),
                .o_st    (st[gi])
            );
        end
        for (gi = 0; gi <= CAP; gi++) begin : g_cvld
            assign car_vld[gi] = car[gi].vld;
        end
    endgenerate

    assign car_any = |car_vld;

    assign s_acc     = s_axis_tvalid & s_axis_tready;
    assign m_acc     = m_axis_tvalid & m_axis_tready;
    assign drain_end = m_acc & ~st[1].vld;

    // results come straight from cell 0
    assign m_axis_tvalid = (r_state == sdu_pkg::ST_DRAIN) & st[0].vld;
    assign m_axis_tdata  = st[0].val;
    assign m_axis_tlast  = ~st[1].vld;
    assign m_axis_tuser  = r_ovf;

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        ctl.probe     = r_probe;
        ctl.shift     = 1'b0;
        case (r_state)
            sdu_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = sdu_pkg::ST_BUSY;
                end
            end
            sdu_pkg::ST_BUSY: begin
                if (!car_any) begin
                    n_state = r_last ? sdu_pkg::ST_DRAIN : sdu_pkg::ST_IDLE;
                end
            end
            sdu_pkg::ST_DRAIN: begin
                ctl.shift = m_acc;
                if (drain_end) begin
                    n_state = sdu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car0_vld <= 1'b0;
            r_probe    <= 1'b0;
            r_last     <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_car0_vld <= s_acc;
            if (s_acc) begin
                r_probe <= st[CAP-1].vld;   // chain full
                r_last  <= s_axis_tlast;
            end
            // a request that runs off the end found no match in a full chain
            if (car[CAP].vld) begin
                r_ovf <= 1'b1;
            end else if (drain_end) begin
                r_ovf <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_car0_val <= s_axis_tdata;
        end
    end

    // only one request is ever in the chain
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(car_vld))
        else $error("more than one request in the chain");

    // head of the chain stays strictly ascending
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st[1].vld |-> (st[0].vld && ($signed(st[0].val) < $signed(st[1].val))))
        else $error("cells 0 and 1 out of order");

    // a request leaves the end only when the chain is full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        car[CAP].vld |-> (r_probe && st[CAP-1].vld))
        else $error("request dropped from a chain that is not full");

    // draining always has a result to show
    a_drain_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdu_pkg::ST_DRAIN) |-> st[0].vld)
        else $error("drain with empty chain");

    // no input taken while a request is in flight
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        car_any |-> !s_axis_tready)
        else $error("input ready during insertion");

endmodule

// ===== hdl/sdu_cell.sv =====
module sdu_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sdu_pkg::t_cell_ctl i_ctl,
    input  sdu_pkg::t_elem     i_car,   // request arriving from the left
    input  sdu_pkg::t_elem     i_nbr,   // stored element of the right neighbor
    output sdu_pkg::t_elem     o_car,   // request handed to the right
    output sdu_pkg::t_elem     o_st     // stored element
);

    logic                       r_st_vld;
    logic [sdu_pkg::DATA_W-1:0] r_st_val;
    logic                       r_car_vld;
    logic [sdu_pkg::DATA_W-1:0] r_car_val;

    logic                       n_st_vld;
    logic [sdu_pkg::DATA_W-1:0] n_st_val;
    logic                       n_car_vld;
    logic [sdu_pkg::DATA_W-1:0] n_car_val;

    always_comb begin
        n_st_vld  = r_st_vld;
        n_st_val  = r_st_val;
        n_car_vld = 1'b0;
        n_car_val = i_car.val;
        if (i_ctl.shift) begin
            n_st_vld = i_nbr.vld;
            n_st_val = i_nbr.val;
        end else if (i_car.vld) begin
            if (!r_st_vld) begin
                // first free slot: settle here
                if (!i_ctl.probe) begin
                    n_st_vld = 1'b1;
                    n_st_val = i_car.val;
                end
            end else if (i_car.val == r_st_val) begin
                // duplicate: merged, request ends
                n_car_vld = 1'b0;
            end else if (!i_ctl.probe && ($signed(i_car.val) < $signed(r_st_val))) begin
                // take the smaller value, push the old one right
                n_st_val  = i_car.val;
                n_car_vld = 1'b1;
                n_car_val = r_st_val;
            end else begin
                n_car_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld  <= 1'b0;
            r_car_vld <= 1'b0;
        end else begin
            r_st_vld  <= n_st_vld;
            r_car_vld <= n_car_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st_val  <= n_st_val;
        r_car_val <= n_car_val;
    end

    assign o_car = '{vld: r_car_vld, val: r_car_val};
    assign o_st  = '{vld: r_st_vld,  val: r_st_val};

endmodule

// ===== verif/sdu_checker.sv =====
module sdu_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [sdu_pkg::DATA_W-1:0] i_s_tdata,   // [31:0] value
    input  logic                       i_s_tlast,   // last

    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [sdu_pkg::DATA_W-1:0] i_m_tdata,   // [31:0] value_res
    input  logic                       i_m_tlast,   // last_res
    input  logic [0:0]                 i_m_tuser,   // [0] overflowed

    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_results,
    output int                         o_flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [sdu_pkg::DATA_W-1:0] value;
        logic                              last;
        logic                              overflowed;
    } t_union_result;

    // distinct values of the open data set, ascending
    logic signed [sdu_pkg::DATA_W-1:0] distinct_set[$];
    logic                              set_dropped = 1'b0;
    t_union_result                     expected_union[$];
    int                                mismatch_cnt;
    int                                result_cnt;
    int                                flagged_cnt;

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // merge one value into the sorted set; a marked value closes the set
    task automatic merge_into_set(input logic signed [sdu_pkg::DATA_W-1:0] v,
                                  input logic mark);
        int            pos;
        t_union_result r;
        pos = 0;
        while (pos < distinct_set.size() && distinct_set[pos] < v)
            pos++;
        if (!(pos < distinct_set.size() && distinct_set[pos] == v)) begin
            if (distinct_set.size() >= sdu_pkg::CAPACITY)
                set_dropped = 1'b1;
            else
                distinct_set.insert(pos, v);
        end
        if (mark) begin
            foreach (distinct_set[k]) begin
                r.value      = distinct_set[k];
                r.last       = (k == distinct_set.size() - 1);
                r.overflowed = set_dropped;
                expected_union.push_back(r);
            end
            distinct_set.delete();
            set_dropped = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_union_result want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                merge_into_set($signed(i_s_tdata), i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                result_cnt++;
                if (i_m_tuser[0])
                    flagged_cnt++;
                if (expected_union.size() == 0) begin
                    report_mismatch($sformatf("result %0d with none expected",
                                              $signed(i_m_tdata)));
                end else begin
                    want = expected_union.pop_front();
                    if (i_m_tdata !== want.value)
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  $signed(i_m_tdata), want.value));
                    if (i_m_tlast !== want.last)
                        report_mismatch($sformatf("tlast %b, expected %b at value %0d",
                                                  i_m_tlast, want.last, want.value));
                    if (i_m_tuser[0] !== want.overflowed)
                        report_mismatch($sformatf("overflow %b, expected %b at value %0d",
                                                  i_m_tuser[0], want.overflowed,
                                                  want.value));
                end
            end
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= expected_union.size();
        o_results    <= result_cnt;
        o_flagged    <= flagged_cnt;
    end

endmodule

// ===== verif/tb_sorted_distinct_union.sv =====
module tb_sorted_distinct_union;
    timeunit 1ns;
    timeprecision 1ps;

    // both sides back off in this many cycles out of a hundred
    localparam int IDLE_PCT    = 36;
    // rough size of the whole stimulus, in requests
    localparam int ITEM_TARGET = 130;
    // stretch of requests with no idling on either side
    localparam int STEADY_LEN  = 40;
    // one long receiver hold-off while the sender keeps offering
    localparam int HOLD_CYCLES = 300;
    // quiet time after the last expected result, catches stray results
    localparam int SETTLE_CYC  = sdu_pkg::CAPACITY + 8;

    typedef struct {
        logic signed [sdu_pkg::DATA_W-1:0] value;
        logic                              last;
    } t_request;

    // value flavors for the small random sets
    typedef enum {
        PICK_NARROW,   // tiny range, lots of repeats
        PICK_WIDE,     // anything in the 32-bit range
        PICK_EDGE      // hugging the signed extremes
    } t_pick;

    logic                       i_clk;
    logic                       i_rst_n;

    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [sdu_pkg::DATA_W-1:0] s_axis_tdata;   // [31:0] value
    logic                       s_axis_tlast;   // last

    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [sdu_pkg::DATA_W-1:0] m_axis_tdata;   // [31:0] value_res
    logic                       m_axis_tlast;   // last_res
    logic [0:0]                 m_axis_tuser;   // [0] overflowed

    int                mismatches;
    int                pending;
    int                results;
    int                flagged;

    t_request          requests[$];
    int                directed_cnt;
    int                set_cnt;
    int                full_sets;
    int                steady_from;
    bit                random_phase;   // past the directed requests
    bit                steady;         // no idling on either side

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    sorted_distinct_union uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // watches both streams, predicts every result and counts mismatches
    sdu_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_m_tuser    (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_flagged    (flagged)
    );

    task automatic add_request(input logic signed [sdu_pkg::DATA_W-1:0] v, input logic mark);
        t_request r;
        r.value = v;
        r.last  = mark;
        requests.push_back(r);
    endtask

    function automatic bit holds(input logic signed [sdu_pkg::DATA_W-1:0] list[$],
                                 input logic signed [sdu_pkg::DATA_W-1:0] v);
        foreach (list[k])
            if (list[k] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    // short set, 1..8 values of one flavor
    task automatic add_small_set();
        int                                n;
        t_pick                             pick;
        logic signed [sdu_pkg::DATA_W-1:0] v;
        n    = $urandom_range(1, 8);
        pick = t_pick'($urandom_range(0, 2));
        for (int k = 0; k < n; k++) begin
            case (pick)
                PICK_NARROW: begin
                    v = $signed($urandom_range(0, 8)) - 4;
                end
                PICK_WIDE: begin
                    v = $urandom;
                end
                default: begin
                    if ($urandom_range(0, 1))
                        v = 32'h7FFF_FFFF - $urandom_range(0, 3);
                    else
                        v = 32'h8000_0000 + $urandom_range(0, 3);
                end
            endcase
            add_request(v, k == n - 1);
        end
    endtask

    // fills the store: CAPACITY distinct values, a repeat that must merge
    // while full, then two new values that get dropped, the marked one last
    task automatic add_full_set();
        logic signed [sdu_pkg::DATA_W-1:0] pool[$];
        logic signed [sdu_pkg::DATA_W-1:0] v;
        pool.push_back(32'h8000_0000);
        pool.push_back(32'h7FFF_FFFF);
        while (pool.size() < sdu_pkg::CAPACITY) begin
            v = $urandom;
            if (!holds(pool, v))
                pool.push_back(v);
        end
        pool.shuffle();
        foreach (pool[k])
            add_request(pool[k], 1'b0);
        add_request(pool[$urandom_range(0, sdu_pkg::CAPACITY - 1)], 1'b0);
        for (int k = 0; k < 2; k++) begin
            do
                v = $urandom;
            while (holds(pool, v));
            add_request(v, k == 1);
        end
    endtask

    task automatic build_requests();
        bit full_done;
        full_done = 1'b0;

        // lone marked item: one result, smallest possible value
        add_request(32'h8000_0000, 1'b1);

        // both extremes, zero and +-1, repeats of all but +1, marked item a repeat
        add_request(32'h7FFF_FFFF, 1'b0);
        add_request(32'h8000_0000, 1'b0);
        add_request(0, 1'b0);
        add_request(-1, 1'b0);
        add_request(1, 1'b0);
        add_request(32'h7FFF_FFFF, 1'b0);
        add_request(0, 1'b0);
        add_request(32'h8000_0000, 1'b0);
        add_request(-1, 1'b1);

        // all the same value: collapses to a single result
        repeat (3)
            add_request(5, 1'b0);
        add_request(5, 1'b1);

        // descending arrival, every value lands in front of the chain
        add_request(100, 1'b0);
        add_request(50, 1'b0);
        add_request(10, 1'b0);
        add_request(-10, 1'b0);
        add_request(-50, 1'b0);
        add_request(-100, 1'b1);

        // alternating bit patterns
        add_request(32'hAAAA_AAAA, 1'b0);
        add_request(32'h5555_5555, 1'b0);
        add_request(1, 1'b1);

        set_cnt      = 5;
        directed_cnt = requests.size();

        while (requests.size() < ITEM_TARGET) begin
            if (!full_done && requests.size() >= directed_cnt + 20) begin
                steady_from = requests.size();
                add_full_set();
                full_done = 1'b1;
                full_sets++;
            end else begin
                add_small_set();
            end
            set_cnt++;
        end
    endtask

    // sender: owns reset and the slave side
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        random_phase  = 1'b0;
        steady        = 1'b0;
        full_sets     = 0;
        steady_from   = ITEM_TARGET;
        build_requests();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int idx = 0; idx < requests.size(); idx++) begin
            random_phase = (idx >= directed_cnt);
            steady       = (idx >= steady_from) && (idx < steady_from + STEADY_LEN);
            // gap cycles carry junk on the bus so nothing leaks through unvalidated
            while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                s_axis_tlast  <= 1'($urandom_range(0, 1));
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= requests[idx].value;
            s_axis_tlast  <= requests[idx].last;
            do
                @(posedge i_clk);
            while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;

        // pending is registered in the checker, let it catch up before polling it
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("%0d requests in %0d data sets, %0d of them past capacity",
                 requests.size(), set_cnt, full_sets);
        $display("%0d results checked, %0d carrying the overflow flag, %0d mismatches",
                 results, flagged, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // receiver: owns m_axis_tready. The first result run of the random part
    // is held off for a long stretch so the block sits in drain while the
    // sender keeps a request waiting.
    initial begin
        bit held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (!held && random_phase && m_axis_tvalid) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #200000;
        $display("timeout: run did not complete");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sorted_distinct_union.f =====
hdl/sdu_pkg.sv
hdl/sdu_cell.sv
hdl/sorted_distinct_union.sv
verif/sdu_checker.sv
verif/tb_sorted_distinct_union.sv
